// ===== hw/rtl/gdfw_pkg.sv =====
// Shared types and codes for the graph depth-first walk core.
package gdfw_pkg;

    localparam int NODE_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_VISIT   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STORED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_E_CNTA,
        S_E_CNTB,
        S_E_WR1,
        S_E_WR2,
        S_E_EMIT,
        S_W_START,
        S_W_LOOP,
        S_W_READ,
        S_W_POP,
        S_W_FINISH
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctrl;

endpackage

// ===== hw/rtl/gdfw_adj_store.sv =====
// Neighbor lists: per-node fill counts and the neighbor entry memory.
module gdfw_adj_store
    import gdfw_pkg::*;
#(
    parameter int NODE_COUNT = 8,
    parameter int MAX_DEGREE = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_mem_ctrl                            i_ctrl,
    input  logic [$clog2(NODE_COUNT)-1:0]        i_node,
    input  logic [$clog2(MAX_DEGREE+1)-1:0]      i_rd_idx,
    input  logic [NODE_W-1:0]                    i_wr_data,
    output logic [$clog2(MAX_DEGREE+1)-1:0]      o_cnt,
    output logic [NODE_W-1:0]                    o_rd_data
);

    localparam int CW    = $clog2(MAX_DEGREE + 1);
    localparam int DIW   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DEPTH = NODE_COUNT * (1 << DIW);

    logic [CW-1:0]     r_cnt [NODE_COUNT];
    logic [NODE_W-1:0] r_mem [DEPTH];
    logic [NODE_W-1:0] r_rd_data;

    assign o_cnt     = r_cnt[i_node];
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODE_COUNT; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_ctrl.wr_en) begin
            r_cnt[i_node] <= r_cnt[i_node] + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[{i_node, DIW'(r_cnt[i_node])}] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[{i_node, DIW'(i_rd_idx)}];
        end
    end

endmodule

// ===== hw/rtl/gdfw_stack.sv =====
// Walk stack memory holding (node, next neighbor index) frames.
module gdfw_stack
    import gdfw_pkg::*;
#(
    parameter int NODE_COUNT = 8,
    parameter int MAX_DEGREE = 8
) (
    input  logic                              i_clk,
    input  t_mem_ctrl                         i_ctrl,
    input  logic [$clog2(NODE_COUNT)-1:0]     i_addr,
    input  logic [NODE_W-1:0]                 i_wr_node,
    input  logic [$clog2(MAX_DEGREE+1)-1:0]   i_wr_idx,
    output logic [NODE_W-1:0]                 o_rd_node,
    output logic [$clog2(MAX_DEGREE+1)-1:0]   o_rd_idx
);

    localparam int CW = $clog2(MAX_DEGREE + 1);

    logic [NODE_W+CW-1:0] r_mem [NODE_COUNT];
    logic [NODE_W+CW-1:0] r_rd;

    assign o_rd_node = r_rd[NODE_W+CW-1:CW];
    assign o_rd_idx  = r_rd[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_addr] <= {i_wr_node, i_wr_idx};
        end
        if (i_ctrl.rd_en) begin
            r_rd <= r_mem[i_addr];
        end
    end

endmodule

// ===== hw/rtl/graph_depth_first_walk_core.sv =====
// Graph depth-first walk core: sequencer, visited marks and result register.
// Usage:
//   Input stream s_*: tuser is the command (0 add edge, 1 search), tdata holds
//   node_a in bits 2:0 and node_b in bits 5:3. s_tready is high only while the
//   sequencer is idle; one item is in work at a time.
//   Output stream m_*: tdata[2:0] is the node, tuser is the status (0 visit,
//   1 when an edge is stored, 2 when it is dropped), tlast marks the final result of an item.
//   Edge sequence: after its transfer an edge passes the count states, the write
//   states if stored, and the emit state, which loads the result. A search scans
//   neighbor entries and pops frames until the start frame is exhausted; each
//   visit is reported when the next one is found, the last one at the end.
//   The neighbor memory has one port with registered read, so each scanned
//   entry is read in the loop state and checked in the read state.
//   A finished result sits in an output register; the sequencer keeps working
//   until it needs that register again, then waits while m_tready is low.
//   Reset (synchronous, active low) clears visited marks, neighbor counts and
//   the stack depth; neighbor entries are undefined until written.
module graph_depth_first_walk_core
    import gdfw_pkg::*;
#(
    parameter int NODE_COUNT = 8,
    parameter int MAX_DEGREE = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // node_a [2:0], node_b [5:3], zero fill
    input  logic [0:0] s_tuser,   // command [0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // node [2:0], zero fill
    output logic [1:0] m_tuser,   // status [1:0]
    output logic       m_tlast
);

    localparam int NIW = $clog2(NODE_COUNT);
    localparam int CW  = $clog2(MAX_DEGREE + 1);
    localparam int SDW = $clog2(NODE_COUNT + 1);
    localparam int SAW = $clog2(NODE_COUNT);

    t_state r_state, n_state;

    logic [NODE_W-1:0]   r_a, r_b, r_pend, r_cur;
    logic [CW-1:0]       r_cnt_a, r_idx;
    logic [STATUS_W-1:0] r_status;
    logic [SDW-1:0]      r_depth;
    logic [NODE_COUNT-1:0] r_visited;

    logic                r_m_valid, r_m_last;
    logic [NODE_W-1:0]   r_m_node;
    logic [STATUS_W-1:0] r_m_status;

    t_mem_ctrl         adj_ctrl, stk_ctrl;
    logic [NODE_W-1:0] adj_node_sel, adj_wr_data, adj_rd_data, stk_node;
    logic [CW-1:0]     adj_cnt, stk_idx;
    logic [SAW-1:0]    stk_addr;

    logic s_acc, out_free, a_ok, b_ok, self_edge, drop, has_next, nxt_new, depth_one;
    logic                out_load, out_last;
    logic [NODE_W-1:0]   out_node;
    logic [STATUS_W-1:0] out_status;

    gdfw_adj_store #(
        .NODE_COUNT (NODE_COUNT),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_adj (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (adj_ctrl),
        .i_node    (NIW'(adj_node_sel)),
        .i_rd_idx  (r_idx),
        .i_wr_data (adj_wr_data),
        .o_cnt     (adj_cnt),
        .o_rd_data (adj_rd_data)
    );

    gdfw_stack #(
        .NODE_COUNT (NODE_COUNT),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_stack (
        .i_clk     (i_clk),
        .i_ctrl    (stk_ctrl),
        .i_addr    (stk_addr),
        .i_wr_node (r_cur),
        .i_wr_idx  (r_idx),
        .o_rd_node (stk_node),
        .o_rd_idx  (stk_idx)
    );

    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !r_m_valid || m_tready;
    assign a_ok      = int'(r_a) < NODE_COUNT;
    assign b_ok      = int'(r_b) < NODE_COUNT;
    assign self_edge = (r_a == r_b);
    assign depth_one = (r_depth == SDW'(1));
    assign has_next  = (r_idx < adj_cnt);
    assign nxt_new   = (int'(adj_rd_data) < NODE_COUNT) && !r_visited[NIW'(adj_rd_data)]
                       && (int'(r_depth) < NODE_COUNT);

    always_comb begin
        if (!a_ok || !b_ok) begin
            drop = 1'b1;
        end else if (self_edge) begin
            drop = (int'(r_cnt_a) + 2) > MAX_DEGREE;
        end else begin
            drop = (int'(r_cnt_a) >= MAX_DEGREE) || (int'(adj_cnt) >= MAX_DEGREE);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = (s_tuser[0] == CMD_ADD) ? S_E_CNTA : S_W_START;
                end
            end
            S_E_CNTA:  n_state = S_E_CNTB;
            S_E_CNTB:  n_state = drop ? S_E_EMIT : S_E_WR1;
            S_E_WR1:   n_state = S_E_WR2;
            S_E_WR2:   n_state = S_E_EMIT;
            S_E_EMIT:  n_state = out_free ? S_IDLE : S_E_EMIT;
            S_W_START: n_state = a_ok ? S_W_LOOP : S_W_FINISH;
            S_W_LOOP: begin
                if (has_next) begin
                    n_state = S_W_READ;
                end else begin
                    n_state = depth_one ? S_W_FINISH : S_W_POP;
                end
            end
            S_W_READ:   n_state = (nxt_new && !out_free) ? S_W_READ : S_W_LOOP;
            S_W_POP:    n_state = S_W_LOOP;
            S_W_FINISH: n_state = out_free ? S_IDLE : S_W_FINISH;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready       = 1'b0;
        adj_ctrl       = '0;
        stk_ctrl       = '0;
        adj_node_sel   = r_cur;
        adj_wr_data    = r_a;
        stk_addr       = SAW'(r_depth - SDW'(1));
        out_load       = 1'b0;
        out_node       = r_pend;
        out_status     = ST_VISIT;
        out_last       = 1'b0;
        unique case (r_state)
            S_IDLE: s_tready = 1'b1;
            S_E_CNTA: adj_node_sel = r_a;
            S_E_CNTB: adj_node_sel = r_b;
            S_E_WR1: begin
                adj_node_sel   = r_a;
                adj_wr_data    = r_b;
                adj_ctrl.wr_en = 1'b1;
            end
            S_E_WR2: begin
                adj_node_sel   = r_b;
                adj_ctrl.wr_en = 1'b1;
            end
            S_E_EMIT: begin
                out_load   = out_free;
                out_node   = '0;
                out_status = r_status;
                out_last   = 1'b1;
            end
            S_W_LOOP: begin
                adj_ctrl.rd_en = has_next;
                stk_ctrl.rd_en = !has_next && !depth_one;
                stk_addr       = SAW'(r_depth - SDW'(2));
            end
            S_W_READ: begin
                stk_ctrl.wr_en = nxt_new && out_free;
                out_load       = nxt_new && out_free;
            end
            S_W_FINISH: begin
                out_load = out_free;
                out_last = 1'b1;
            end
            S_W_START, S_W_POP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_depth   <= '0;
            r_visited <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_W_START: begin
                    if (a_ok) begin
                        r_visited[NIW'(r_a)] <= 1'b1;
                        r_depth              <= SDW'(1);
                    end
                end
                S_W_LOOP: begin
                    if (!has_next && !depth_one) begin
                        r_depth <= r_depth - SDW'(1);
                    end
                end
                S_W_READ: begin
                    if (nxt_new && out_free) begin
                        r_visited[NIW'(adj_rd_data)] <= 1'b1;
                        r_depth                      <= r_depth + SDW'(1);
                    end
                end
                S_W_FINISH: begin
                    if (out_free) begin
                        r_depth <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_a <= s_tdata[2:0];
                    r_b <= s_tdata[5:3];
                end
            end
            S_E_CNTA: r_cnt_a <= adj_cnt;
            S_E_CNTB: r_status <= drop ? ST_DROPPED : ST_STORED;
            S_W_START: begin
                r_pend <= r_a;
                r_cur  <= r_a;
                r_idx  <= '0;
            end
            S_W_LOOP: begin
                if (has_next) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            S_W_READ: begin
                if (nxt_new && out_free) begin
                    r_pend <= adj_rd_data;
                    r_cur  <= adj_rd_data;
                    r_idx  <= '0;
                end
            end
            S_W_POP: begin
                r_cur <= stk_node;
                r_idx <= stk_idx;
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_node   <= out_node;
            r_m_status <= out_status;
            r_m_last   <= out_last;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {5'b0, r_m_node};
    assign m_tuser  = r_m_status;
    assign m_tlast  = r_m_last;

    a_top_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W_LOOP) |-> r_visited[NIW'(r_cur)])
        else $error("walk frame on top of stack is not marked visited");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_depth) <= NODE_COUNT)
        else $error("stack depth beyond node count");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> (r_depth == '0))
        else $error("stack not empty while idle");

    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W_FINISH && out_free) |=> (r_m_valid && r_m_last && r_depth == '0))
        else $error("search end did not load a last visit report");

endmodule
